FILE: sv/grs_pkg.sv
// Shared types and constants for the grid bucket radius search block.
package grs_pkg;

  localparam int COORD_W = 14;
  localparam int CUR_W   = 16;
  localparam int SQ_W    = 28;
  localparam int DIST_W  = 29;
  localparam int EMPTY_W = 13;
  localparam int REQ_W   = 2;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FETCH  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  localparam logic [COORD_W-1:0] CENTER_RESET = 14'd8192;
  localparam logic [COORD_W-1:0] RADIUS_RESET = 14'd4096;

  typedef struct packed {
    logic [CUR_W-1:0] lo;
    logic [CUR_W-1:0] hi;
  } axis_range_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INS_CELL,
    ST_INS_LINK,
    ST_F_CELL,
    ST_F_STEP,
    ST_F_PT,
    ST_F_CMP,
    ST_RESP
  } state_t;

endpackage

FILE: sv/grs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module grs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/grs_axis.sv
// Clipped cell range of the query box along one axis.
module grs_axis #(
  parameter int CELLS_PER_SIDE = 64,
  parameter int FRACTION_BITS  = 8
) (
  input  logic [grs_pkg::COORD_W-1:0] center,
  input  logic [grs_pkg::COORD_W-1:0] radius,
  output grs_pkg::axis_range_t        range
);

  logic [grs_pkg::CUR_W-1:0] sum;
  logic [grs_pkg::CUR_W-1:0] top;
  logic [grs_pkg::CUR_W-1:0] diff;

  assign sum  = grs_pkg::CUR_W'(center) + grs_pkg::CUR_W'(radius);
  assign top  = sum >> FRACTION_BITS;
  assign diff = grs_pkg::CUR_W'(center) - grs_pkg::CUR_W'(radius);

  always_comb begin
    range.lo = (center < radius) ? '0 : (diff >> FRACTION_BITS);
    range.hi = (top > grs_pkg::CUR_W'(CELLS_PER_SIDE - 1)) ? grs_pkg::CUR_W'(CELLS_PER_SIDE - 1)
                                                            : top;
  end

endmodule

FILE: sv/grid_bucket_radius_search.sv
// Fixed-radius neighbor search over a uniform cell grid. Points are binned by the integer
// part of their coordinates; each cell keeps its points as a linked list in a point RAM,
// with head, tail and an occupied bit per cell in a cell RAM. A stored insert passes through
// ST_INS_CELL, then ST_INS_LINK when the cell already holds a point and its tail link
// must be rewritten, then ST_RESP, from which its result is registered. A
// fetch reads one cell or one listed point per visit, so its latency follows the data
// between two matches. A clear, and the period after reset, sweeps all
// CELLS_PER_SIDE*CELLS_PER_SIDE entries of the cell RAM one entry a cycle, and no
// transaction is taken on the input channel meanwhile. Configuration may be written at
// any time the block idles.
module grid_bucket_radius_search #(
  parameter int CELLS_PER_SIDE = 64,
  parameter int MAX_POINTS     = 4096,
  parameter int FRACTION_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [grs_pkg::REQ_W-1:0]     in_req_type,
  input  logic [grs_pkg::COORD_W-1:0]   in_point_x,
  input  logic [grs_pkg::COORD_W-1:0]   in_point_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_match_valid,
  output logic [grs_pkg::COORD_W-1:0]   out_match_x,
  output logic [grs_pkg::COORD_W-1:0]   out_match_y,
  output logic                          out_search_done,
  output logic [grs_pkg::EMPTY_W-1:0]   out_empty_cells,
  output logic                          out_store_full,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [grs_pkg::ADDR_W-1:0]    paddr,
  input  logic [grs_pkg::DATA_W-1:0]    pwdata,
  output logic [grs_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int NUM_CELLS = CELLS_PER_SIDE * CELLS_PER_SIDE;
  localparam int CAW       = $clog2(NUM_CELLS);
  localparam int PAW       = $clog2(MAX_POINTS);
  localparam int PIW       = $clog2(MAX_POINTS + 1);
  localparam int ECW       = $clog2(NUM_CELLS + 1);
  localparam int CELL_W    = 1 + 2 * PAW;
  localparam int PT_W      = 2 * grs_pkg::COORD_W + PIW;
  localparam logic [PIW-1:0] NO_POINT = PIW'(MAX_POINTS);

  localparam int CW = grs_pkg::COORD_W;
  localparam int UW = grs_pkg::CUR_W;

  function automatic logic [CAW-1:0] cell_addr(input logic [UW-1:0] cx,
                                               input logic [UW-1:0] cy);
    cell_addr = CAW'(32'(cx) * CELLS_PER_SIDE + 32'(cy));
  endfunction

  // Configuration registers
  logic [CW-1:0] cx_r, cy_r, rad_r;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r  <= grs_pkg::CENTER_RESET;
      cy_r  <= grs_pkg::CENTER_RESET;
      rad_r <= grs_pkg::RADIUS_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        grs_pkg::REG_CENTER_X: cx_r  <= pwdata[CW-1:0];
        grs_pkg::REG_CENTER_Y: cy_r  <= pwdata[CW-1:0];
        grs_pkg::REG_RADIUS:   rad_r <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      grs_pkg::REG_CENTER_X: prdata = grs_pkg::DATA_W'(cx_r);
      grs_pkg::REG_CENTER_Y: prdata = grs_pkg::DATA_W'(cy_r);
      grs_pkg::REG_RADIUS:   prdata = grs_pkg::DATA_W'(rad_r);
      default:               prdata = '0;
    endcase
  end

  // Query box from the current registers
  grs_pkg::axis_range_t box_x, box_y;

  grs_axis #(.CELLS_PER_SIDE(CELLS_PER_SIDE), .FRACTION_BITS(FRACTION_BITS)) u_axis_x (
    .center(cx_r), .radius(rad_r), .range(box_x)
  );
  grs_axis #(.CELLS_PER_SIDE(CELLS_PER_SIDE), .FRACTION_BITS(FRACTION_BITS)) u_axis_y (
    .center(cy_r), .radius(rad_r), .range(box_y)
  );

  // Memories
  logic              cm_we;
  logic [CAW-1:0]    cm_waddr, cm_raddr;
  logic [CELL_W-1:0] cm_wdata, cm_rdata;
  logic              pm_we;
  logic [PAW-1:0]    pm_waddr, pm_raddr;
  logic [PT_W-1:0]   pm_wdata, pm_rdata;

  grs_ram #(.WIDTH(CELL_W), .DEPTH(NUM_CELLS)) u_cell_ram (
    .clk(clk), .we(cm_we), .waddr(cm_waddr), .wdata(cm_wdata),
    .raddr(cm_raddr), .rdata(cm_rdata)
  );
  grs_ram #(.WIDTH(PT_W), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk(clk), .we(pm_we), .waddr(pm_waddr), .wdata(pm_wdata),
    .raddr(pm_raddr), .rdata(pm_rdata)
  );

  logic           rd_occ;
  logic [PAW-1:0] rd_head, rd_tail;
  logic [CW-1:0]  rd_px, rd_py;
  logic [PIW-1:0] rd_next;

  assign rd_occ  = cm_rdata[CELL_W-1];
  assign rd_head = cm_rdata[2*PAW-1:PAW];
  assign rd_tail = cm_rdata[PAW-1:0];
  assign rd_px   = pm_rdata[PT_W-1 -: CW];
  assign rd_py   = pm_rdata[PIW+CW-1 -: CW];
  assign rd_next = pm_rdata[PIW-1:0];

  // State
  grs_pkg::state_t state_r, state_nxt;
  logic [CAW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic            clr_reply_r, clr_reply_nxt;
  logic [PIW-1:0]  count_r, count_nxt;
  logic [ECW-1:0]  empty_r, empty_nxt;
  logic [UW-1:0]   cur_x_r, cur_x_nxt, cur_y_r, cur_y_nxt;
  logic [PIW-1:0]  cur_pt_r, cur_pt_nxt;
  logic            active_r, active_nxt;
  logic [UW-1:0]   bx0_r, bx0_nxt, bx1_r, bx1_nxt, by0_r, by0_nxt, by1_r, by1_nxt;
  logic [grs_pkg::SQ_W-1:0] r2_r, r2_nxt, sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [CW-1:0]   px_r, px_nxt, py_r, py_nxt;
  logic [CAW-1:0]  ins_cell_r, ins_cell_nxt;
  logic [PAW-1:0]  ins_tail_r, ins_tail_nxt;
  logic [PIW-1:0]  ins_idx_r, ins_idx_nxt;
  logic            res_mv_r, res_mv_nxt, res_done_r, res_done_nxt, res_full_r, res_full_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_mv_r, out_done_r, out_full_r;
  logic [CW-1:0]   out_x_r, out_y_r;
  logic [grs_pkg::EMPTY_W-1:0] out_empty_r;

  logic           accept, out_free, clr_last;
  logic [UW-1:0]  ins_ix, ins_iy, adv_x, adv_y;
  logic           ins_out, box_empty, pt_live, adv_end;
  logic signed [CW:0]     dx, dy;
  logic signed [2*CW+1:0] dx2, dy2;
  logic [grs_pkg::DIST_W-1:0] d2;
  logic [31:0]    empty32;

  assign in_stall = (state_r != grs_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign clr_last = (clr_cnt_r == CAW'(NUM_CELLS - 1));

  assign ins_ix    = UW'({2'b00, in_point_x} >> FRACTION_BITS);
  assign ins_iy    = UW'({2'b00, in_point_y} >> FRACTION_BITS);
  assign ins_out   = (ins_ix >= UW'(CELLS_PER_SIDE)) || (ins_iy >= UW'(CELLS_PER_SIDE));
  assign box_empty = (box_x.lo > box_x.hi) || (box_y.lo > box_y.hi);
  assign pt_live   = (cur_pt_r != NO_POINT);

  // Next cell of the walk, row-major with y as the inner index.
  always_comb begin
    adv_y = cur_y_r + UW'(1);
    adv_x = cur_x_r;
    if (adv_y > by1_r) begin
      adv_y = by0_r;
      adv_x = cur_x_r + UW'(1);
    end
    adv_end = (adv_x > bx1_r) || (adv_x >= UW'(CELLS_PER_SIDE)) ||
              (adv_y >= UW'(CELLS_PER_SIDE));
  end

  assign dx  = $signed({1'b0, rd_px}) - $signed({1'b0, cx_r});
  assign dy  = $signed({1'b0, rd_py}) - $signed({1'b0, cy_r});
  assign dx2 = dx * dx;
  assign dy2 = dy * dy;
  assign d2  = grs_pkg::DIST_W'(sqx_r) + grs_pkg::DIST_W'(sqy_r);

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      grs_pkg::ST_CLEAR: begin
        if (clr_last) begin
          state_nxt = clr_reply_r ? grs_pkg::ST_RESP : grs_pkg::ST_IDLE;
        end
      end
      grs_pkg::ST_IDLE: begin
        if (accept) begin
          priority case (in_req_type)
            grs_pkg::REQ_INSERT: begin
              state_nxt = (ins_out || count_r == NO_POINT) ? grs_pkg::ST_RESP
                                                            : grs_pkg::ST_INS_CELL;
            end
            grs_pkg::REQ_FETCH: begin
              if (active_r) state_nxt = grs_pkg::ST_F_STEP;
              else          state_nxt = box_empty ? grs_pkg::ST_RESP : grs_pkg::ST_F_CELL;
            end
            grs_pkg::REQ_CLEAR: state_nxt = grs_pkg::ST_CLEAR;
            default:            state_nxt = grs_pkg::ST_RESP;
          endcase
        end
      end
      grs_pkg::ST_INS_CELL: state_nxt = rd_occ ? grs_pkg::ST_INS_LINK : grs_pkg::ST_RESP;
      grs_pkg::ST_INS_LINK: state_nxt = grs_pkg::ST_RESP;
      grs_pkg::ST_F_CELL:   state_nxt = grs_pkg::ST_F_STEP;
      grs_pkg::ST_F_STEP: begin
        if (pt_live)      state_nxt = grs_pkg::ST_F_PT;
        else if (adv_end) state_nxt = grs_pkg::ST_RESP;
        else              state_nxt = grs_pkg::ST_F_CELL;
      end
      grs_pkg::ST_F_PT:  state_nxt = grs_pkg::ST_F_CMP;
      grs_pkg::ST_F_CMP: begin
        state_nxt = (d2 <= grs_pkg::DIST_W'(r2_r)) ? grs_pkg::ST_RESP : grs_pkg::ST_F_STEP;
      end
      grs_pkg::ST_RESP: if (out_free) state_nxt = grs_pkg::ST_IDLE;
      default: state_nxt = grs_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    clr_reply_nxt = clr_reply_r;
    count_nxt     = count_r;
    empty_nxt     = empty_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    cur_pt_nxt    = cur_pt_r;
    active_nxt    = active_r;
    bx0_nxt = bx0_r; bx1_nxt = bx1_r; by0_nxt = by0_r; by1_nxt = by1_r;
    r2_nxt  = r2_r;
    sqx_nxt = sqx_r;
    sqy_nxt = sqy_r;
    px_nxt  = px_r;
    py_nxt  = py_r;
    ins_cell_nxt = ins_cell_r;
    ins_tail_nxt = ins_tail_r;
    ins_idx_nxt  = ins_idx_r;
    res_mv_nxt   = res_mv_r;
    res_done_nxt = res_done_r;
    res_full_nxt = res_full_r;
    cm_we    = 1'b0;
    cm_waddr = clr_cnt_r;
    cm_wdata = '0;
    cm_raddr = cell_addr(cur_x_r, cur_y_r);
    pm_we    = 1'b0;
    pm_waddr = ins_tail_r;
    pm_wdata = {rd_px, rd_py, ins_idx_r};
    pm_raddr = cur_pt_r[PAW-1:0];

    unique case (state_r)
      grs_pkg::ST_CLEAR: begin
        cm_we       = 1'b1;
        clr_cnt_nxt = clr_cnt_r + CAW'(1);
        if (clr_last) begin
          count_nxt  = '0;
          empty_nxt  = ECW'(NUM_CELLS);
          cur_x_nxt  = '0;
          cur_y_nxt  = '0;
          cur_pt_nxt = NO_POINT;
          active_nxt = 1'b0;
        end
      end
      grs_pkg::ST_IDLE: begin
        res_mv_nxt   = 1'b0;
        res_done_nxt = 1'b0;
        res_full_nxt = 1'b0;
        bx0_nxt = box_x.lo; bx1_nxt = box_x.hi;
        by0_nxt = box_y.lo; by1_nxt = box_y.hi;
        r2_nxt  = grs_pkg::SQ_W'(rad_r) * grs_pkg::SQ_W'(rad_r);
        px_nxt  = in_point_x;
        py_nxt  = in_point_y;
        ins_cell_nxt = cell_addr(ins_ix, ins_iy);
        cm_raddr = (in_req_type == grs_pkg::REQ_FETCH) ? cell_addr(box_x.lo, box_y.lo)
                                                       : cell_addr(ins_ix, ins_iy);
        if (accept) begin
          priority case (in_req_type)
            grs_pkg::REQ_INSERT: begin
              res_full_nxt = !ins_out && (count_r == NO_POINT);
            end
            grs_pkg::REQ_FETCH: begin
              if (!active_r) begin
                if (box_empty) begin
                  res_done_nxt = 1'b1;
                end else begin
                  cur_x_nxt  = box_x.lo;
                  cur_y_nxt  = box_y.lo;
                  active_nxt = 1'b1;
                end
              end
            end
            grs_pkg::REQ_CLEAR: begin
              clr_cnt_nxt   = '0;
              clr_reply_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      grs_pkg::ST_INS_CELL: begin
        pm_we    = 1'b1;
        pm_waddr = count_r[PAW-1:0];
        pm_wdata = {px_r, py_r, NO_POINT};
        cm_we    = 1'b1;
        cm_waddr = ins_cell_r;
        cm_wdata = rd_occ ? {1'b1, rd_head, count_r[PAW-1:0]}
                          : {1'b1, count_r[PAW-1:0], count_r[PAW-1:0]};
        pm_raddr     = rd_tail;
        ins_tail_nxt = rd_tail;
        ins_idx_nxt  = count_r;
        count_nxt    = count_r + PIW'(1);
        if (!rd_occ) empty_nxt = empty_r - ECW'(1);
      end
      grs_pkg::ST_INS_LINK: begin
        pm_we = 1'b1;
      end
      grs_pkg::ST_F_CELL: begin
        cur_pt_nxt = rd_occ ? PIW'(rd_head) : NO_POINT;
      end
      grs_pkg::ST_F_STEP: begin
        if (!pt_live) begin
          cur_x_nxt = adv_x;
          cur_y_nxt = adv_y;
          cm_raddr  = cell_addr(adv_x, adv_y);
          if (adv_end) begin
            active_nxt   = 1'b0;
            cur_pt_nxt   = NO_POINT;
            res_done_nxt = 1'b1;
          end
        end
      end
      grs_pkg::ST_F_PT: begin
        cur_pt_nxt = (cur_pt_r[PAW-1:0] == rd_tail) ? NO_POINT : rd_next;
        sqx_nxt    = dx2[grs_pkg::SQ_W-1:0];
        sqy_nxt    = dy2[grs_pkg::SQ_W-1:0];
        px_nxt     = rd_px;
        py_nxt     = rd_py;
      end
      grs_pkg::ST_F_CMP: begin
        res_mv_nxt = (d2 <= grs_pkg::DIST_W'(r2_r));
      end
      grs_pkg::ST_RESP: begin
        clr_reply_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  assign empty32 = 32'(empty_r);
  assign out_valid_nxt = (state_r == grs_pkg::ST_RESP && out_free) ? 1'b1
                       : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grs_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      clr_reply_r <= 1'b0;
      count_r     <= '0;
      empty_r     <= ECW'(NUM_CELLS);
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cur_pt_r    <= NO_POINT;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_reply_r <= clr_reply_nxt;
      count_r     <= count_nxt;
      empty_r     <= empty_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      cur_pt_r    <= cur_pt_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bx0_r <= bx0_nxt; bx1_r <= bx1_nxt; by0_r <= by0_nxt; by1_r <= by1_nxt;
    r2_r  <= r2_nxt;
    sqx_r <= sqx_nxt;
    sqy_r <= sqy_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    ins_cell_r <= ins_cell_nxt;
    ins_tail_r <= ins_tail_nxt;
    ins_idx_r  <= ins_idx_nxt;
    res_mv_r   <= res_mv_nxt;
    res_done_r <= res_done_nxt;
    res_full_r <= res_full_nxt;
    // The output register loads only when the previous transaction has left.
    if (state_r == grs_pkg::ST_RESP && out_free) begin
      out_mv_r    <= res_mv_r;
      out_x_r     <= res_mv_r ? px_r : '0;
      out_y_r     <= res_mv_r ? py_r : '0;
      out_done_r  <= res_done_r;
      out_full_r  <= res_full_r;
      out_empty_r <= (empty32 > 32'd8191) ? grs_pkg::EMPTY_W'(8191) : empty32[grs_pkg::EMPTY_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_match_valid = out_mv_r;
  assign out_match_x     = out_x_r;
  assign out_match_y     = out_y_r;
  assign out_search_done = out_done_r;
  assign out_empty_cells = out_empty_r;
  assign out_store_full  = out_full_r;

endmodule

FILE: sv/grs_checker.sv
// Port-level checks for the grid bucket radius search block, with its bind.
module grs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_match_valid,
  input logic [grs_pkg::COORD_W-1:0] out_match_x,
  input logic [grs_pkg::COORD_W-1:0] out_match_y,
  input logic                        out_search_done,
  input logic                        out_store_full
);

  // A transaction carries at most one of match, end of walk and store full.
  a_match_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_match_valid |-> !out_search_done && !out_store_full)
    else $error("match reported together with done or full");

  a_full_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_store_full |-> !out_search_done)
    else $error("store full reported on a fetch end");

  a_zero_coords: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_match_valid |-> out_match_x == '0 && out_match_y == '0)
    else $error("coordinates nonzero without a match");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_match_x) && $stable(out_match_y))
    else $error("stalled result changed");

endmodule

bind grid_bucket_radius_search grs_checker u_grs_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_match_valid(out_match_valid), .out_match_x(out_match_x),
  .out_match_y(out_match_y), .out_search_done(out_search_done),
  .out_store_full(out_store_full)
);
